// File: sv/rae_pkg.sv
// Shared operation codes and queue status type for the register ALU execute unit.
package rae_pkg;

    localparam int OP_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_AND = 4'd1,
        OP_ASR = 4'd2,
        OP_LSR = 4'd3,
        OP_LSL = 4'd4,
        OP_ORR = 4'd5,
        OP_SUB = 4'd6,
        OP_XOR = 4'd7,
        OP_MOV = 4'd8
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: sv/rae_front.sv
// Front end: accept instructions, check opcode and register numbers, push good ones.
module rae_front #(
    parameter int NUM_REGS   = 8,
    parameter int DATA_WIDTH = 32,
    parameter int QW         = 4 + 3 * $clog2(NUM_REGS) + DATA_WIDTH
) (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [3:0]       s_tuser,   // kind
    input  logic [47:0]      s_tdata,   // dest_index, src_a_index, src_b_index, immediate
    input  rae_pkg::q_stat_t q_stat,
    output logic             push,
    output logic [QW-1:0]    push_data
);
    import rae_pkg::*;

    localparam int RW = $clog2(NUM_REGS);
    localparam int CW = ((RW > 3) ? RW : 3) + 1;

    logic [CW-1:0] rd_ext;
    logic [CW-1:0] ra_ext;
    logic [CW-1:0] rb_ext;
    logic          one_src;
    logic          two_src;
    logic          kind_ok;
    logic          regs_ok;

    assign rd_ext = CW'(s_tdata[2:0]);
    assign ra_ext = CW'(s_tdata[5:3]);
    assign rb_ext = CW'(s_tdata[8:6]);

    always_comb
    begin
        one_src = 1'b0;
        two_src = 1'b0;
        kind_ok = 1'b1;
        unique case (s_tuser) inside
            OP_ASR, OP_LSR, OP_LSL:                 one_src = 1'b1;
            OP_ADD, OP_AND, OP_ORR, OP_SUB, OP_XOR: two_src = 1'b1;
            OP_MOV:                                 ;
            default:                                kind_ok = 1'b0;
        endcase
    end

    // Check only the register numbers the operation really uses.
    assign regs_ok = (rd_ext < CW'(NUM_REGS))
                   && (!(one_src || two_src) || (ra_ext < CW'(NUM_REGS)))
                   && (!two_src || (rb_ext < CW'(NUM_REGS)));

    assign s_tready  = !q_stat.full;
    // Bad instructions are still taken from the bus, then dropped.
    assign push      = s_tvalid && !q_stat.full && kind_ok && regs_ok;
    assign push_data = {DATA_WIDTH'(s_tdata[40:9]), rb_ext[RW-1:0], ra_ext[RW-1:0],
                        rd_ext[RW-1:0], s_tuser};

endmodule

// File: sv/rae_queue.sv
// Small FIFO between the decode front end and the execute back end.
module rae_queue #(
    parameter int QW    = 45,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [QW-1:0]    push_data,
    input  logic             pop,
    output logic [QW-1:0]    head_data,
    output rae_pkg::q_stat_t q_stat
);
    import rae_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [QW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    assign head_data    = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (PW+1)'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// File: sv/rae_back.sv
// Back end: register file read, ALU, register write-back and output register.
module rae_back #(
    parameter int NUM_REGS   = 8,
    parameter int DATA_WIDTH = 32,
    parameter int QW         = 4 + 3 * $clog2(NUM_REGS) + DATA_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rae_pkg::q_stat_t q_stat,
    input  logic [QW-1:0]    head_data,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata    // written_index, written_value
);
    import rae_pkg::*;

    localparam int RW = $clog2(NUM_REGS);
    localparam int DW = DATA_WIDTH;

    logic [DW-1:0]       rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;

    op_t           q_op;
    logic [RW-1:0] q_rd;
    logic [RW-1:0] q_ra;
    logic [RW-1:0] q_rb;
    logic [DW-1:0] q_imm;

    logic          e_vld_reg;
    op_t           e_op_reg;
    logic [RW-1:0] e_rd_reg;
    logic [RW-1:0] e_ra_reg;
    logic [RW-1:0] e_rb_reg;
    logic [DW-1:0] e_imm_reg;
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;
    logic          a_ok_reg;
    logic          b_ok_reg;

    logic          wb_vld_reg;
    logic [RW-1:0] wb_idx_reg;
    logic [DW-1:0] wb_val_reg;

    logic          out_vld_reg;
    logic          out_vld_next;
    logic [2:0]    out_idx_reg;
    logic [31:0]   out_val_reg;

    logic          e_adv;
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
    logic [DW-1:0] alu_res;

    assign q_op  = op_t'(head_data[OP_W-1:0]);
    assign q_rd  = head_data[OP_W +: RW];
    assign q_ra  = head_data[OP_W + RW +: RW];
    assign q_rb  = head_data[OP_W + 2*RW +: RW];
    assign q_imm = head_data[OP_W + 3*RW +: DW];

    assign e_adv = e_vld_reg && (!out_vld_reg || m_tready);
    assign pop   = !q_stat.empty && (!e_vld_reg || e_adv);

    // Register file and operand stage; the read sees the file before this edge's write.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_a_reg  <= rf_mem[q_ra];
            rd_b_reg  <= rf_mem[q_rb];
            a_ok_reg  <= rf_vld_reg[q_ra];
            b_ok_reg  <= rf_vld_reg[q_rb];
            e_op_reg  <= q_op;
            e_rd_reg  <= q_rd;
            e_ra_reg  <= q_ra;
            e_rb_reg  <= q_rb;
            e_imm_reg <= q_imm;
        end
        if (e_adv)
        begin
            rf_mem[e_rd_reg] <= alu_res;
            wb_idx_reg       <= e_rd_reg;
            wb_val_reg       <= alu_res;
            out_idx_reg      <= 3'(e_rd_reg);
            out_val_reg      <= 32'(alu_res);
        end
    end

    // Bypass the latest write, which the operand read may have missed.
    always_comb
    begin
        opa = a_ok_reg ? rd_a_reg : '0;
        opb = b_ok_reg ? rd_b_reg : '0;
        if (wb_vld_reg && (wb_idx_reg == e_ra_reg))
            opa = wb_val_reg;
        if (wb_vld_reg && (wb_idx_reg == e_rb_reg))
            opb = wb_val_reg;
    end

    always_comb
    begin
        unique case (e_op_reg)
            OP_ADD:  alu_res = opa + opb;
            OP_AND:  alu_res = opa & opb;
            OP_ASR:  alu_res = {opa[DW-1], opa[DW-1:1]};
            OP_LSR:  alu_res = {1'b0, opa[DW-1:1]};
            OP_LSL:  alu_res = {opa[DW-2:0], 1'b0};
            OP_ORR:  alu_res = opa | opb;
            OP_SUB:  alu_res = opa - opb;
            OP_XOR:  alu_res = opa ^ opb;
            default: alu_res = e_imm_reg;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (e_adv)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg  <= '0;
            e_vld_reg   <= 1'b0;
            wb_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                e_vld_reg <= 1'b1;
            else if (e_adv)
                e_vld_reg <= 1'b0;
            if (e_adv)
            begin
                rf_vld_reg[e_rd_reg] <= 1'b1;
                wb_vld_reg           <= 1'b1;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_val_reg, out_idx_reg};

endmodule

// File: sv/register_alu_execute_unit.sv
// Top level of the register ALU execute unit: front end, queue, back end.
//
// Usage: each slave-side transfer carries one decoded instruction; s_tuser holds the
// operation (add, and, asr, lsr, lsl, orr, sub, xor, mov) and s_tdata the destination,
// the two source register numbers and the immediate. Each good instruction writes its
// destination register and gives one master-side transfer with the register number
// and its new value. An instruction with an unknown operation or a used register
// number at or above NUM_REGS is taken and dropped with no result.
// Throughput: one instruction per cycle while m_tready is high, set by the single
// operand-read and ALU stage; the previous instruction's result is bypassed to the next.
// Path: with the queue empty, an instruction passes the queue, the operand register and
// the output register before its result is on m_tdata.
// Reset: all registers read as zero, the queue and pipeline are empty.
// Stall: with m_tready low the output register holds, the ALU stage holds behind it,
// and the four-entry queue keeps taking input until it fills, then s_tready drops.
module register_alu_execute_unit #(
    parameter int NUM_REGS   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [3:0]  s_tuser,    // [3:0] kind
    input  logic [47:0] s_tdata,    // [2:0] dest_index, [5:3] src_a_index,
                                    // [8:6] src_b_index, [40:9] immediate, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [2:0] written_index, [34:3] written_value, rest zero
);
    import rae_pkg::*;

    localparam int QW = OP_W + 3 * $clog2(NUM_REGS) + DATA_WIDTH;

    q_stat_t       q_stat;
    logic          q_push;
    logic          q_pop;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_head;

    // Decode and check; push good instructions.
    rae_front #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH),
        .QW         (QW)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_in)
    );

    // Decouple decode from execute so each side can stall alone.
    rae_queue #(
        .QW    (QW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_head),
        .q_stat    (q_stat)
    );

    // Read operands, execute, write back and present the result.
    rae_back #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH),
        .QW         (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_data (q_head),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // Never pop an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // An empty queue stays empty without a push.
    a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.empty && !q_push) |=> q_stat.empty)
        else $error("queue filled without push");

endmodule
